// ===== src/dnv_pkg.sv =====
// Package for the decimal number validator.
// Holds the per-string state and configuration structs and the character codes.
// No dependencies.
package dnv_pkg;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] SEP_RESET    = 8'd46;
  localparam logic [7:0] MARKER_RESET = 8'd101;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DECIMAL_SEPARATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGER_ONLY      = 2'd2;

  typedef struct packed {
    logic [7:0] decimal_separator;
    logic [7:0] exponent_marker;
    logic       integer_only;
  } dnv_cfg_t;

  typedef struct packed {
    logic at_string_start;
    logic after_marker;
    logic separator_seen;
    logic marker_seen;
    logic string_failed;
    logic all_blank;
  } dnv_state_t;

  localparam dnv_state_t STATE_CLEAR = '{
    at_string_start: 1'b1,
    after_marker:    1'b0,
    separator_seen:  1'b0,
    marker_seen:     1'b0,
    string_failed:   1'b0,
    all_blank:       1'b1
  };

endpackage

// ===== src/dnv_cfg_regs.sv =====
// Configuration registers of the decimal number validator.
// Depends on dnv_pkg for the register indexes and the configuration struct.
module dnv_cfg_regs import dnv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output dnv_cfg_t              cfg
);

  dnv_cfg_t cfg_r;
  dnv_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DECIMAL_SEPARATOR: cfg_nxt.decimal_separator = cfg_wdata;
        REG_EXPONENT_MARKER:   cfg_nxt.exponent_marker   = cfg_wdata;
        REG_INTEGER_ONLY:      cfg_nxt.integer_only      = cfg_wdata[0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decimal_separator <= SEP_RESET;
      cfg_r.exponent_marker   <= MARKER_RESET;
      cfg_r.integer_only      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/dnv_char_check.sv =====
// Per-character rule check of the decimal number validator.
// Combinational: takes the string state, one character and the configuration,
// and gives the next state and the verdict. Depends on dnv_pkg.
module dnv_char_check import dnv_pkg::*; (
  input  dnv_state_t state,
  input  dnv_cfg_t   cfg,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output dnv_state_t state_nxt,
  output logic       number_valid
);

  logic       is_blank;
  logic       is_digit;
  logic       is_sign;
  logic       fail;
  logic       sep_seen;
  logic       mark_seen;
  logic       next_after;
  logic       blank;

  assign is_blank = ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR)) ||
                    (char_code == CHAR_SPACE);
  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_sign  = (char_code == CHAR_MINUS) || (char_code == CHAR_PLUS);

  always_comb begin
    fail       = state.string_failed;
    sep_seen   = state.separator_seen;
    mark_seen  = state.marker_seen;
    next_after = 1'b0;
    blank      = state.all_blank && is_blank;
    if (!state.string_failed) begin
      if (state.at_string_start && (char_code == CHAR_MINUS)) begin
        fail = 1'b0;
      end else if (state.after_marker && is_sign) begin
        if ((cfg.integer_only && (char_code == CHAR_MINUS)) || last_char) begin
          fail = 1'b1;
        end
      end else if (!cfg.integer_only && (char_code == cfg.decimal_separator)) begin
        if (state.separator_seen) begin
          fail = 1'b1;
        end
        sep_seen = 1'b1;
      end else if (char_code == cfg.exponent_marker) begin
        if (last_char || state.marker_seen) begin
          fail = 1'b1;
        end
        mark_seen  = 1'b1;
        next_after = 1'b1;
        if (!cfg.integer_only) begin
          sep_seen = 1'b1;
        end
      end else if (!is_digit) begin
        fail = 1'b1;
      end
    end
  end

  always_comb begin
    if (last_char) begin
      state_nxt = STATE_CLEAR;
    end else begin
      state_nxt.at_string_start = 1'b0;
      state_nxt.after_marker    = next_after;
      state_nxt.separator_seen  = sep_seen;
      state_nxt.marker_seen     = mark_seen;
      state_nxt.string_failed   = fail;
      state_nxt.all_blank       = blank;
    end
  end

  assign number_valid = !fail && !blank;

endmodule

// ===== src/decimal_number_validator.sv =====
// Top level of the decimal number validator: input register, rule check,
// string state and result register. Depends on dnv_pkg, dnv_cfg_regs and
// dnv_char_check.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_tvalid/tready   | tdata = char_code, tlast = last_char
//   out_    | output    | out_tvalid/tready  | tdata = number_valid
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One item is accepted per cycle unless a last character waits on a stalled result.
// A verdict is offered once its last character has passed the input register and
// its verdict has been loaded into the result register.
// Reset is synchronous; it clears the string state and both valids and loads the
// configuration registers with their reset values.
// A stalled result blocks only a further last character; other characters
// keep flowing and update the string state.
module decimal_number_validator import dnv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_code
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] number_valid, [7:1] zero
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dnv_cfg_t   cfg;
  dnv_state_t state_r;
  dnv_state_t state_nxt;
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_last_r;
  logic       out_valid_r;
  logic       out_bit_r;
  logic       verdict;
  logic       advance;

  dnv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dnv_char_check u_check (
    .state        (state_r),
    .cfg          (cfg),
    .char_code    (in_char_r),
    .last_char    (in_last_r),
    .state_nxt    (state_nxt),
    .number_valid (verdict)
  );

  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_CLEAR;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && in_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance && in_last_r) begin
      out_bit_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};

  a_reset_clears: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (!out_tvalid && !in_valid_r && state_r.at_string_start))
    else $error("valids or string state not cleared after reset");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |=> (state_r == STATE_CLEAR && out_tvalid))
    else $error("last character did not clear state and raise a result");

  a_blocked_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && in_last_r && out_tvalid && !out_tready) |=>
    (in_valid_r && in_last_r && $stable(in_char_r)))
    else $error("blocked last character lost");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("string state changed without an item");

endmodule
